// ===== src/csa_pkg.sv =====
`default_nettype none

package csa_pkg;

    // table geometry
    localparam int TABLE_SIZE = 64;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int IN_SLOT_W  = 16;
    localparam int OUT_SLOT_W = 12;
    localparam int WORD_W     = 32;
    localparam int ENTRY_W    = 4 * WORD_W;

    // request kinds (code 3 is unused)
    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

endpackage

`default_nettype wire

// ===== src/capability_slot_allocator_top.sv =====
`default_nettype none

// Capability slot allocator: a 64-entry table of capability entries (service
// id, epoch, permissions, endpoint handle) with a stack of free slot indices.
// Each input item is an alloc (op 0), a free (op 1) or a lookup (op 2) and
// gives exactly one result item; op 3 answers "index out of range". In the
// accept cycle the free stack and the entry table (both synchronous
// single-read memories) are addressed; in the execute state that follows,
// the read data is used, the result is formed and the entry / stack writes
// are done. The next item is accepted in the cycle after the execute state
// completes, so the block does not take a new item before it is through
// with the last one; a pending result waits in the output register while
// the next item is accepted, and the block holds in its execute cycle
// only if the previous result has not yet been taken. There is no clearing
// pass after reset: per-entry valid bits (cleared by reset) make an
// unwritten entry read as all zero and an unwritten stack element read as
// its own index. Double free is not detected.
module capability_slot_allocator_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          op,
    input  wire logic [csa_pkg::IN_SLOT_W-1:0]       slot_in,
    input  wire logic [csa_pkg::WORD_W-1:0]          new_service_id,
    input  wire logic [csa_pkg::WORD_W-1:0]          new_epoch,
    input  wire logic [csa_pkg::WORD_W-1:0]          new_permissions,
    input  wire logic [csa_pkg::WORD_W-1:0]          new_endpoint,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [1:0]                               status,
    output logic [csa_pkg::OUT_SLOT_W-1:0]           slot_out,
    output logic [csa_pkg::WORD_W-1:0]               entry_service_id,
    output logic [csa_pkg::WORD_W-1:0]               entry_epoch,
    output logic [csa_pkg::WORD_W-1:0]               entry_permissions,
    output logic [csa_pkg::WORD_W-1:0]               entry_endpoint
);
    import csa_pkg::*;

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0]    entry_mem  [TABLE_SIZE];
    logic [SLOT_W-1:0]     stack_mem  [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] ent_vld_reg;
    logic [TABLE_SIZE-1:0] stk_vld_reg;
    logic [CNT_W-1:0]      free_count_reg;

    // read ports, registered
    logic [ENTRY_W-1:0]    ent_rd_reg;
    logic                  ent_rd_vld_reg;
    logic [SLOT_W-1:0]     stk_rd_reg;
    logic                  stk_rd_vld_reg;
    logic [SLOT_W-1:0]     stk_rd_addr_reg;

    // captured request
    logic [1:0]            req_op_reg;
    logic [IN_SLOT_W-1:0]  req_slot_reg;
    logic [ENTRY_W-1:0]    req_entry_reg;

    state_t                state_reg, state_next;

    // output register
    logic                  out_valid_reg;
    logic [1:0]            status_reg;
    logic [OUT_SLOT_W-1:0] slot_out_reg;
    logic [ENTRY_W-1:0]    entry_out_reg;

    logic                  accept;
    logic                  advance;
    logic [SLOT_W-1:0]     stk_rd_addr;
    logic [SLOT_W-1:0]     ent_rd_addr;

    // execute-cycle decisions
    status_t               res_status;
    logic [OUT_SLOT_W-1:0] res_slot;
    logic [ENTRY_W-1:0]    res_entry;
    logic                  ent_we;
    logic [SLOT_W-1:0]     ent_waddr;
    logic [ENTRY_W-1:0]    ent_wdata;
    logic                  stk_we;
    logic [SLOT_W-1:0]     stk_waddr;
    logic [SLOT_W-1:0]     stk_wdata;
    logic                  cnt_dec;
    logic                  cnt_inc;
    logic [SLOT_W-1:0]     pop_idx;
    logic [ENTRY_W-1:0]    rd_entry;
    logic                  req_in_range;

    assign accept  = in_valid && in_ready;
    // the result register must be free (or being emptied) to finish an item
    assign advance = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    // top of stack lives one below the count
    assign stk_rd_addr = SLOT_W'(free_count_reg - CNT_W'(1));
    assign ent_rd_addr = slot_in[SLOT_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (advance)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // Memory read ports and request capture
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ent_rd_reg      <= entry_mem[ent_rd_addr];
            stk_rd_reg      <= stack_mem[stk_rd_addr];
            stk_rd_addr_reg <= stk_rd_addr;
            req_op_reg      <= op;
            req_slot_reg    <= slot_in;
            req_entry_reg   <= {new_service_id, new_epoch, new_permissions, new_endpoint};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_rd_vld_reg <= 1'b0;
            stk_rd_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            ent_rd_vld_reg <= ent_vld_reg[ent_rd_addr];
            stk_rd_vld_reg <= stk_vld_reg[stk_rd_addr];
        end
    end

    // unwritten stack element holds its own index; unwritten entry is zero
    assign pop_idx      = stk_rd_vld_reg ? stk_rd_reg : stk_rd_addr_reg;
    assign rd_entry     = ent_rd_vld_reg ? ent_rd_reg : '0;
    assign req_in_range = (req_slot_reg < IN_SLOT_W'(TABLE_SIZE));

    // ------------------------------------------------------------------
    // Execute: result and write-back
    // ------------------------------------------------------------------
    always_comb
    begin
        res_status = ST_OK;
        res_slot   = '0;
        res_entry  = '0;
        ent_we     = 1'b0;
        ent_waddr  = pop_idx;
        ent_wdata  = req_entry_reg;
        stk_we     = 1'b0;
        stk_waddr  = free_count_reg[SLOT_W-1:0];
        stk_wdata  = req_slot_reg[SLOT_W-1:0];
        cnt_dec    = 1'b0;
        cnt_inc    = 1'b0;
        unique case (req_op_reg)
            OP_ALLOC:
            begin
                if (free_count_reg == '0)
                    res_status = ST_NOSPACE;
                else
                begin
                    res_slot = OUT_SLOT_W'(pop_idx);
                    ent_we   = 1'b1;
                    cnt_dec  = 1'b1;
                end
            end
            OP_FREE:
            begin
                if (!req_in_range)
                    res_status = ST_RANGE;
                else if (free_count_reg >= CNT_W'(TABLE_SIZE))
                    res_status = ST_FULL;
                else
                begin
                    // invalidated entry: service id all ones, rest zero
                    ent_we    = 1'b1;
                    ent_waddr = req_slot_reg[SLOT_W-1:0];
                    ent_wdata = {{WORD_W{1'b1}}, {(3 * WORD_W){1'b0}}};
                    stk_we    = 1'b1;
                    cnt_inc   = 1'b1;
                end
            end
            OP_LOOKUP:
            begin
                if (!req_in_range)
                    res_status = ST_RANGE;
                else
                    res_entry = rd_entry;
            end
            default: res_status = ST_RANGE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance && ent_we)
            entry_mem[ent_waddr] <= ent_wdata;
        if (advance && stk_we)
            stack_mem[stk_waddr] <= stk_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg    <= '0;
            stk_vld_reg    <= '0;
            free_count_reg <= CNT_W'(TABLE_SIZE);
        end
        else if (advance)
        begin
            if (ent_we)
                ent_vld_reg[ent_waddr] <= 1'b1;
            if (stk_we)
                stk_vld_reg[stk_waddr] <= 1'b1;
            if (cnt_dec)
                free_count_reg <= free_count_reg - CNT_W'(1);
            else if (cnt_inc)
                free_count_reg <= free_count_reg + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg    <= res_status;
            slot_out_reg  <= res_slot;
            entry_out_reg <= res_entry;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign slot_out          = slot_out_reg;
    assign entry_service_id  = entry_out_reg[4*WORD_W-1:3*WORD_W];
    assign entry_epoch       = entry_out_reg[3*WORD_W-1:2*WORD_W];
    assign entry_permissions = entry_out_reg[2*WORD_W-1:WORD_W];
    assign entry_endpoint    = entry_out_reg[WORD_W-1:0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= CNT_W'(TABLE_SIZE))
        else $error("free count above table size");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result raised outside execute cycle");

    a_alloc_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && req_op_reg == OP_ALLOC && res_status == ST_OK)
        |=> free_count_reg == $past(free_count_reg) - CNT_W'(1))
        else $error("successful alloc did not pop the stack");

    a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && !advance) |=> state_reg == S_EXEC && !accept)
        else $error("item accepted while previous one still executing");

endmodule

`default_nettype wire
